FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the Farey term generator.
// No dependencies; both macros expect i_clk, FSG_ASSERT also i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define FSG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fsg assertion failed");
// checked at every edge, reset included
`define FSG_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("fsg assertion failed");
`else
`define FSG_ASSERT(lbl, prop)
`define FSG_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hdl/fsg_pkg.sv
// Shared types and constants for the Farey term generator.
// No dependencies.
`default_nettype none
package fsg_pkg;

    localparam int MAX_DENOM_DEF = 255;
    localparam int FRAC_W        = 8;
    localparam int CFG_W         = 8;
    localparam logic [CFG_W-1:0] CFG_RESET = 8'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_MUL_L,
        S_MUL_R,
        S_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;   // request beat taken
        logic init;   // start candidate scan
        logic mul_l;  // p * best_q
        logic mul_r;  // best_p * q
        logic cmp;    // compare, keep best, step q
        logic emit;   // write result register and term state
    } t_cmd;

    typedef struct packed {
        logic trivial;  // request answers 0/1 without a scan
        logic q_done;   // last denominator reached
        logic out_free; // result register can take a beat
    } t_sts;

endpackage
`default_nettype wire

FILE: hdl/fsg_datapath.sv
// Datapath: order register, current term, candidate scan with one shared
// multiplier, result register. Depends on fsg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fsg_datapath
    import fsg_pkg::*;
#(
    parameter int MAX_DENOM = MAX_DENOM_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic              i_restart,
    input  wire logic              i_cfg_valid,
    input  wire logic [CFG_W-1:0]  i_cfg_max_denom,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [FRAC_W-1:0]      o_numerator,
    output logic [FRAC_W-1:0]      o_denominator,
    output logic                   o_last
);

    localparam int QW_RAW = $clog2(MAX_DENOM + 1);
    localparam int QW     = (QW_RAW > FRAC_W) ? QW_RAW : FRAC_W;
    localparam int PW     = 2 * QW;

    logic [CFG_W-1:0]  r_cfg;
    logic [FRAC_W-1:0] r_cur_num, r_cur_den;
    logic              r_begun, r_zero;
    logic [QW-1:0]     r_q, r_quot, r_best_p, r_best_q;
    logic [FRAC_W-1:0] r_rem;
    logic [PW-1:0]     r_lhs, r_rhs;
    logic              r_out_valid, r_out_last;
    logic [FRAC_W-1:0] r_out_num, r_out_den;

    logic [QW-1:0]     ord_lim, p_cand, mul_a, mul_b;
    logic [FRAC_W-1:0] d_eff, res_num, res_den;
    logic [FRAC_W:0]   rem_sum;
    logic              rem_wrap;
    logic [PW-1:0]     prod;

    // effective order: zero means 1, saturate at MAX_DENOM
    always_comb begin
        if (r_cfg == '0) begin
            ord_lim = QW'(1);
        end else if (QW'(r_cfg) > QW'(MAX_DENOM)) begin
            ord_lim = QW'(MAX_DENOM);
        end else begin
            ord_lim = QW'(r_cfg);
        end
    end

    assign d_eff    = (r_cur_den == '0) ? FRAC_W'(1) : r_cur_den;
    // floor(c*q/d) tracked incrementally; c < d so it grows by at most one per q
    assign rem_sum  = {1'b0, r_rem} + {1'b0, r_cur_num};
    assign rem_wrap = rem_sum >= {1'b0, d_eff};
    assign p_cand   = r_quot + QW'(1);

    assign mul_a = i_cmd.mul_l ? p_cand   : r_best_p;
    assign mul_b = i_cmd.mul_l ? r_best_q : r_q;
    assign prod  = PW'(mul_a) * PW'(mul_b);

    assign res_num = r_zero ? '0         : r_best_p[FRAC_W-1:0];
    assign res_den = r_zero ? FRAC_W'(1) : r_best_q[FRAC_W-1:0];

    assign o_sts.trivial  = i_restart || !r_begun || (r_cur_num >= d_eff);
    assign o_sts.q_done   = (r_q == ord_lim);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_cur_num   <= '0;
            r_cur_den   <= FRAC_W'(1);
            r_begun     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_max_denom;
            end
            if (i_cmd.emit) begin
                r_cur_num   <= res_num;
                r_cur_den   <= res_den;
                r_begun     <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= o_sts.trivial;
        end
        if (i_cmd.init) begin
            r_q      <= QW'(1);
            r_quot   <= '0;
            r_rem    <= r_cur_num;
            r_best_p <= QW'(1);
            r_best_q <= QW'(1);
        end
        if (i_cmd.mul_l) begin
            r_lhs <= prod;
        end
        if (i_cmd.mul_r) begin
            r_rhs <= prod;
        end
        if (i_cmd.cmp) begin
            if (r_lhs < r_rhs) begin
                r_best_p <= p_cand;
                r_best_q <= r_q;
            end
            r_q <= r_q + QW'(1);
            if (rem_wrap) begin
                r_rem  <= rem_sum[FRAC_W-1:0] - d_eff;
                r_quot <= r_quot + QW'(1);
            end else begin
                r_rem  <= rem_sum[FRAC_W-1:0];
            end
        end
        if (i_cmd.emit) begin
            r_out_num  <= res_num;
            r_out_den  <= res_den;
            r_out_last <= (res_num == FRAC_W'(1)) && (res_den == FRAC_W'(1));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_numerator   = r_out_num;
    assign o_denominator = r_out_den;
    assign o_last        = r_out_last;

    `FSG_ASSERT(a_rem_below_den, i_cmd.cmp |-> (r_rem < d_eff))
    `FSG_ASSERT(a_q_in_order, i_cmd.cmp |-> (r_q <= ord_lim))
    `FSG_ASSERT(a_best_proper, i_cmd.cmp |-> (r_best_p <= r_best_q))

endmodule
`default_nettype wire

FILE: hdl/fsg_ctrl.sv
// Controller FSM: sequences request load, candidate scan and result write.
// Depends on fsg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fsg_ctrl
    import fsg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.trivial ? S_EMIT : S_INIT;
                end
            end
            S_INIT:  n_state = S_MUL_L;
            S_MUL_L: n_state = S_MUL_R;
            S_MUL_R: n_state = S_CMP;
            S_CMP:   n_state = i_sts.q_done ? S_EMIT : S_MUL_L;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_INIT:  o_cmd.init  = 1'b1;
            S_MUL_L: o_cmd.mul_l = 1'b1;
            S_MUL_R: o_cmd.mul_r = 1'b1;
            S_CMP:   o_cmd.cmp   = 1'b1;
            S_EMIT:  o_cmd.emit  = i_sts.out_free;
            default: o_cmd       = '0;
        endcase
    end

    `FSG_ASSERT_ALWAYS(a_one_cmd, $onehot0(o_cmd))
    `FSG_ASSERT(a_emit_has_room, o_cmd.emit |-> i_sts.out_free)
    `FSG_ASSERT(a_mul_order, (r_state == S_MUL_L) |=> (r_state == S_MUL_R))

endmodule
`default_nettype wire

FILE: hdl/farey_sequence_generator.sv
// Top level of the Farey sequence term generator.
// Depends on fsg_pkg, fsg_ctrl and fsg_datapath.
//
// channel  dir  handshake                     payload
// in       in   i_in_valid / o_in_ready       i_restart
// out      out  o_out_valid / i_out_ready     o_numerator, o_denominator, o_last
// cfg      in   i_cfg_valid / o_cfg_ready     i_cfg_max_denom
//
// A restart, the first request after reset, or a request after 1/1 skips the scan
// and loads 0/1 into the result register in S_EMIT. Any other request scans every
// denominator up to the order n with one shared multiplier, through S_MUL_L,
// S_MUL_R and S_CMP for each denominator, and then writes the result in S_EMIT.
// Reset is synchronous, active low; order resets to 1. A new request is taken once
// the previous result sits in the output register; a full one holds the input too.
`default_nettype none
module farey_sequence_generator
    import fsg_pkg::*;
#(
    parameter int MAX_DENOM = MAX_DENOM_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_restart,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [FRAC_W-1:0]      o_numerator,
    output logic [FRAC_W-1:0]      o_denominator,
    output logic                   o_last,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_max_denom
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    fsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fsg_datapath #(
        .MAX_DENOM (MAX_DENOM)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_restart       (i_restart),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_max_denom (i_cfg_max_denom),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_numerator     (o_numerator),
        .o_denominator   (o_denominator),
        .o_last          (o_last)
    );

endmodule
`default_nettype wire

FILE: dv/farey_sequence_generator_test.sv
// Self-checking testbench for farey_sequence_generator: a directed table, then random
// request phases at changing orders, with random gaps on both sides.
// Depends on fsg_pkg and the RTL of farey_sequence_generator.
`default_nettype none
module farey_sequence_generator_test;
    import fsg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int ORDER_CAP    = MAX_DENOM_DEF;
    localparam int ITEMS_TARGET = 1800;
    localparam int SQUEEZE_LEN  = 300;
    localparam int NUM_ROWS     = 28;

    typedef struct packed {
        logic [FRAC_W-1:0] num;
        logic [FRAC_W-1:0] den;
        logic              last;
    } t_term;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [CFG_W-1:0]  value;  // order for ROW_CFG, bit 0 = restart for ROW_REQ
        logic              typed;
        t_term             want;
    } t_plan_row;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              i_restart       = 1'b0;
    logic              i_out_ready     = 1'b0;
    logic              i_cfg_valid     = 1'b0;
    logic [CFG_W-1:0]  i_cfg_max_denom = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [FRAC_W-1:0] o_numerator;
    logic [FRAC_W-1:0] o_denominator;
    logic              o_last;
    logic              o_cfg_ready;

    farey_sequence_generator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_numerator     (o_numerator),
        .o_denominator   (o_denominator),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_max_denom (i_cfg_max_denom)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state: the term last emitted and the programmed order
    logic [FRAC_W-1:0] term_num   = '0;
    logic [FRAC_W-1:0] term_den   = 8'd1;
    logic              term_begun = 1'b0;
    logic [CFG_W-1:0]  order_reg  = CFG_RESET;

    t_term       pending_terms[$];
    int unsigned items_sent  = 0;
    int unsigned errors      = 0;
    logic        flood_phase = 1'b0;

    t_plan_row directed_plan [NUM_ROWS] = '{
        '{ROW_REQ, 8'd0,   1'b1, '{8'd0, 8'd1,   1'b0}},  // advance before any term
        '{ROW_REQ, 8'd0,   1'b1, '{8'd1, 8'd1,   1'b1}},
        '{ROW_REQ, 8'd0,   1'b1, '{8'd0, 8'd1,   1'b0}},  // wrap after the end
        '{ROW_REQ, 8'd1,   1'b1, '{8'd0, 8'd1,   1'b0}},
        '{ROW_REQ, 8'd0,   1'b1, '{8'd1, 8'd1,   1'b1}},
        '{ROW_REQ, 8'd1,   1'b1, '{8'd0, 8'd1,   1'b0}},  // restart from 1/1
        '{ROW_REQ, 8'd0,   1'b1, '{8'd1, 8'd1,   1'b1}},
        '{ROW_CFG, 8'd0,   1'b0, '0},                     // order zero acts as one
        '{ROW_REQ, 8'd0,   1'b1, '{8'd0, 8'd1,   1'b0}},
        '{ROW_REQ, 8'd0,   1'b1, '{8'd1, 8'd1,   1'b1}},
        '{ROW_CFG, 8'd255, 1'b0, '0},
        '{ROW_REQ, 8'd1,   1'b1, '{8'd0, 8'd1,   1'b0}},
        '{ROW_REQ, 8'd0,   1'b1, '{8'd1, 8'd255, 1'b0}},
        '{ROW_REQ, 8'd0,   1'b1, '{8'd1, 8'd254, 1'b0}},
        '{ROW_CFG, 8'd5,   1'b0, '0},                     // order drops mid-sequence
        '{ROW_REQ, 8'd0,   1'b0, '0},
        '{ROW_REQ, 8'd0,   1'b0, '0},
        '{ROW_CFG, 8'd2,   1'b0, '0},
        '{ROW_REQ, 8'd0,   1'b0, '0},
        '{ROW_CFG, 8'd255, 1'b0, '0},                     // order rises mid-sequence
        '{ROW_REQ, 8'd0,   1'b0, '0},
        '{ROW_CFG, 8'd3,   1'b0, '0},
        '{ROW_REQ, 8'd0,   1'b0, '0},
        '{ROW_REQ, 8'd0,   1'b1, '{8'd1, 8'd1,   1'b1}},
        '{ROW_CFG, 8'd255, 1'b0, '0},
        '{ROW_REQ, 8'd0,   1'b1, '{8'd0, 8'd1,   1'b0}},
        '{ROW_REQ, 8'd0,   1'b1, '{8'd1, 8'd255, 1'b0}},
        '{ROW_REQ, 8'd1,   1'b1, '{8'd0, 8'd1,   1'b0}}
    };

    // Next term: least p/q > term, q <= order, ties to smaller q; or 0/1 on restart.
    function automatic t_term farey_advance(input logic restart_bit);
        int unsigned n, q, p, best_p, best_q, c, d;
        t_term       t;
        n = order_reg;
        if (n == 0) n = 1;
        if (n > ORDER_CAP) n = ORDER_CAP;
        c = term_num;
        d = term_den;
        best_p = 0;
        best_q = 1;
        if (!restart_bit && term_begun && c < d) begin
            best_p = 1;
            for (q = 1; q <= n; q++) begin
                p = (c * q) / d + 1;
                if (p * best_q < best_p * q) begin
                    best_p = p;
                    best_q = q;
                end
            end
        end
        term_num   = best_p[FRAC_W-1:0];
        term_den   = best_q[FRAC_W-1:0];
        term_begun = 1'b1;
        t.num  = term_num;
        t.den  = term_den;
        t.last = (term_num == 8'd1) && (term_den == 8'd1);
        return t;
    endfunction

    function automatic int unsigned pick_gap(input logic steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(input string what);
        errors++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic queue_expected(input t_term t);
        pending_terms = {pending_terms, t};
    endtask

    task automatic check_term();
        t_term want;
        if (pending_terms.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat %0d/%0d last=%0b",
                o_numerator, o_denominator, o_last));
            return;
        end
        want = pending_terms.pop_front();
        if (o_numerator !== want.num)
            flag_mismatch($sformatf("numerator %0d, expected %0d", o_numerator, want.num));
        if (o_denominator !== want.den)
            flag_mismatch($sformatf("denominator %0d, expected %0d",
                o_denominator, want.den));
        if (o_last !== want.last)
            flag_mismatch($sformatf("last %0b, expected %0b", o_last, want.last));
    endtask

    task automatic send_request(input logic restart_bit, input logic steady,
                                input logic typed, input t_term typed_term);
        t_term       t;
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_restart  <= restart_bit;
        do @(posedge i_clk); while (!o_in_ready);
        t = farey_advance(restart_bit);
        queue_expected(typed ? typed_term : t);
        items_sent++;
        // valid stays up when the next beat follows at once
        gap = pick_gap(steady);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_until_idle();
        i_in_valid  <= 1'b0;
        flood_phase <= 1'b0;
        while (pending_terms.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [CFG_W-1:0] value);
        i_cfg_valid     <= 1'b1;
        i_cfg_max_denom <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        order_reg = value;
    endtask

    // result side: random stalls, plus one long hold at the start of each flood phase
    int unsigned rx_stall     = 0;
    int unsigned squeeze_left = 0;
    logic        rx_steady    = 1'b0;
    logic        squeezed     = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_term();
                rx_stall = pick_gap(rx_steady);
                if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
            end
            if (flood_phase && !squeezed) begin
                squeezed     = 1'b1;
                squeeze_left = SQUEEZE_LEN;
            end else if (!flood_phase) begin
                squeezed = 1'b0;
            end
            if (squeeze_left != 0) begin
                squeeze_left--;
                i_out_ready <= 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned      phase, r, count, restart_pct;
        logic [CFG_W-1:0] order_sel;
        logic             flood, steady;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_CFG) begin
                wait_until_idle();
                write_order(directed_plan[i].value);
            end else begin
                send_request(directed_plan[i].value[0], 1'b0,
                             directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // mostly small orders; large orders are slow, so they get only a few beats
        phase = 0;
        while (items_sent < ITEMS_TARGET) begin
            flood = (phase % 10 == 2);
            r = $urandom_range(0, 99);
            if (flood)       order_sel = CFG_W'($urandom_range(2, 12));
            else if (r < 4)  order_sel = '0;
            else if (r < 70) order_sel = CFG_W'($urandom_range(1, 12));
            else if (r < 88) order_sel = CFG_W'($urandom_range(13, 48));
            else if (r < 95) order_sel = CFG_W'($urandom_range(49, 254));
            else             order_sel = 8'd255;
            if (flood)                count = 60;
            else if (order_sel <= 48) count = $urandom_range(10, 80);
            else                      count = $urandom_range(2, 8);
            restart_pct = $urandom_range(1, 15);
            steady      = flood || ($urandom_range(0, 4) == 0);
            wait_until_idle();
            write_order(order_sel);
            flood_phase <= flood;
            repeat (count)
                send_request($urandom_range(0, 99) < restart_pct, steady, 1'b0, '0);
            phase++;
        end

        wait_until_idle();
        repeat (3 * ORDER_CAP + 10) @(posedge i_clk);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin : watchdog
        #(100_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/fsg_pkg.sv
hdl/fsg_datapath.sv
hdl/fsg_ctrl.sv
hdl/farey_sequence_generator.sv
dv/farey_sequence_generator_test.sv
